[sv/incremental_pid_slow_start_unit_defines.svh]
// Assertion helpers for the incremental PID slow-start unit.
// Every check is sampled on the rising clock and is off while reset is held.
`ifndef INCREMENTAL_PID_SLOW_START_UNIT_DEFINES_SVH
`define INCREMENTAL_PID_SLOW_START_UNIT_DEFINES_SVH

// Same-cycle implication
`define IPSS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define IPSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ipss_pkg.sv]
package ipss_pkg;

    // Fixed field widths
    localparam int TARGET_W   = 16;
    localparam int COEF_W     = 24;
    localparam int DRIVE_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Parameter defaults
    localparam int MEAS_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Increment limit and slow-start step, in whole units
    localparam int INC_LIMIT_UNITS = 5;
    localparam int SLOW_STEP_UNITS = 1;

    // Action codes
    localparam logic [1:0] ACT_COMPUTE  = 2'd0;
    localparam logic [1:0] ACT_SET_GATE = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CUR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BPREV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER      = 3'd5;

    // What an item asks for, carried down the pipeline
    typedef struct packed {
        logic [1:0] action;
        logic       new_gate;
    } tag_t;

    // Configuration register set
    typedef struct packed {
        logic signed [TARGET_W-1:0] target;
        logic signed [COEF_W-1:0]   coef_cur;
        logic signed [COEF_W-1:0]   coef_prev;
        logic signed [COEF_W-1:0]   coef_bprev;
        logic signed [DRIVE_W-1:0]  upper;
        logic signed [DRIVE_W-1:0]  lower;
    } cfg_t;

    // Error width: wide enough for target minus measured
    function automatic int err_width(input int meas_w);
        return ((meas_w > TARGET_W) ? meas_w : TARGET_W) + 1;
    endfunction

endpackage

[sv/ipss_cfg.sv]
module ipss_cfg
    import ipss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Decode the register index and capture the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET:     cfg_reg.target     <= cfg_data[TARGET_W-1:0];
                CFG_COEF_CUR:   cfg_reg.coef_cur   <= cfg_data[COEF_W-1:0];
                CFG_COEF_PREV:  cfg_reg.coef_prev  <= cfg_data[COEF_W-1:0];
                CFG_COEF_BPREV: cfg_reg.coef_bprev <= cfg_data[COEF_W-1:0];
                CFG_UPPER:      cfg_reg.upper      <= cfg_data[DRIVE_W-1:0];
                CFG_LOWER:      cfg_reg.lower      <= cfg_data[DRIVE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/ipss_error.sv]
module ipss_error
    import ipss_pkg::*;
#(
    parameter int MEAS_WIDTH = MEAS_WIDTH_DEF,
    localparam int ERR_W     = err_width(MEAS_WIDTH)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tag_t                         in_tag,
    input  logic signed [MEAS_WIDTH-1:0] in_meas,
    input  logic signed [TARGET_W-1:0]   target,
    output logic                         out_valid,
    input  logic                         out_ready,
    output tag_t                         out_tag,
    output logic signed [ERR_W-1:0]      err,
    output logic signed [ERR_W-1:0]      err_last,
    output logic signed [ERR_W-1:0]      err_before
);

    logic                    valid_reg;
    tag_t                    tag_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] el_reg;
    logic signed [ERR_W-1:0] eb_reg;
    logic signed [ERR_W-1:0] hist_last_reg;
    logic signed [ERR_W-1:0] hist_last_next;
    logic signed [ERR_W-1:0] hist_before_reg;
    logic signed [ERR_W-1:0] hist_before_next;
    logic signed [ERR_W-1:0] err_cur;
    logic                    load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign err_cur  = ERR_W'(target) - ERR_W'(in_meas);

    // Shift or clear the error history in item order
    always_comb
    begin
        hist_last_next   = hist_last_reg;
        hist_before_next = hist_before_reg;
        if (load)
        begin
            case (in_tag.action)
                ACT_COMPUTE:
                begin
                    hist_before_next = hist_last_reg;
                    hist_last_next   = err_cur;
                end
                ACT_CLEAR:
                begin
                    hist_before_next = '0;
                    hist_last_next   = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            hist_last_reg   <= '0;
            hist_before_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            hist_last_reg   <= hist_last_next;
            hist_before_reg <= hist_before_next;
        end
    end

    // Capture the error and the history it is weighed against
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tag_reg <= in_tag;
            err_reg <= err_cur;
            el_reg  <= hist_last_reg;
            eb_reg  <= hist_before_reg;
        end
    end

    assign out_valid  = valid_reg;
    assign out_tag    = tag_reg;
    assign err        = err_reg;
    assign err_last   = el_reg;
    assign err_before = eb_reg;

endmodule

[sv/ipss_increment.sv]
module ipss_increment
    import ipss_pkg::*;
#(
    parameter int MEAS_WIDTH = MEAS_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int ERR_W     = err_width(MEAS_WIDTH),
    localparam int PROD_W    = COEF_W + ERR_W,
    localparam int INC_W     = PROD_W + 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  tag_t                    in_tag,
    input  logic signed [ERR_W-1:0] err,
    input  logic signed [ERR_W-1:0] err_last,
    input  logic signed [ERR_W-1:0] err_before,
    input  cfg_t                    cfg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output tag_t                    out_tag,
    output logic signed [INC_W-1:0] inc,
    output logic                    over
);

    localparam logic signed [INC_W-1:0] INC_LIMIT = INC_W'(INC_LIMIT_UNITS) <<< FRAC_BITS;

    logic signed [COEF_W-1:0] c_cur;
    logic signed [COEF_W-1:0] c_prev;
    logic signed [COEF_W-1:0] c_bprev;

    logic                     b_valid_reg;
    logic                     b_ready;
    tag_t                     b_tag_reg;
    logic signed [PROD_W-1:0] p_cur_reg;
    logic signed [PROD_W-1:0] p_prev_reg;
    logic signed [PROD_W-1:0] p_bprev_reg;

    logic                     c_valid_reg;
    logic                     c_ready;
    tag_t                     c_tag_reg;
    logic signed [INC_W-1:0]  inc_next;
    logic signed [INC_W-1:0]  inc_reg;
    logic                     over_next;
    logic                     over_reg;

    assign c_cur   = cfg.coef_cur;
    assign c_prev  = cfg.coef_prev;
    assign c_bprev = cfg.coef_bprev;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = b_ready;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
            begin
                b_valid_reg <= in_valid;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Weigh each error by its coefficient
    always_ff @(posedge clk)
    begin
        if (in_valid && b_ready)
        begin
            b_tag_reg   <= in_tag;
            p_cur_reg   <= PROD_W'(c_cur) * PROD_W'(err);
            p_prev_reg  <= PROD_W'(c_prev) * PROD_W'(err_last);
            p_bprev_reg <= PROD_W'(c_bprev) * PROD_W'(err_before);
        end
    end

    // Sum the weighted errors and test against the limit
    assign inc_next  = INC_W'(p_cur_reg) - INC_W'(p_prev_reg) + INC_W'(p_bprev_reg);
    assign over_next = inc_next > INC_LIMIT;

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && c_ready)
        begin
            c_tag_reg <= b_tag_reg;
            inc_reg   <= inc_next;
            over_reg  <= over_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_tag   = c_tag_reg;
    assign inc       = inc_reg;
    assign over      = over_reg;

endmodule

[sv/ipss_drive.sv]
module ipss_drive
    import ipss_pkg::*;
#(
    parameter int MEAS_WIDTH = MEAS_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int ERR_W     = err_width(MEAS_WIDTH),
    localparam int INC_W     = COEF_W + ERR_W + 2,
    localparam int SUM_W     = INC_W + 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tag_t                      in_tag,
    input  logic signed [INC_W-1:0]   in_inc,
    input  logic                      in_over,
    input  cfg_t                      cfg,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      gate,
    output logic                      held,
    output logic                      load
);

    localparam logic signed [SUM_W-1:0] STEP = SUM_W'(SLOW_STEP_UNITS) <<< FRAC_BITS;

    logic signed [DRIVE_W-1:0] upper;
    logic signed [DRIVE_W-1:0] lower;
    logic                      valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      gate_reg;
    logic                      gate_next;
    logic                      held_reg;
    logic                      held_next;
    logic signed [SUM_W-1:0]   addend;
    logic signed [SUM_W-1:0]   sum;
    logic signed [DRIVE_W-1:0] clamped;

    assign upper    = cfg.upper;
    assign lower    = cfg.lower;
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Add the increment, or the slow-start step, to the drive
    assign addend = in_over ? STEP : SUM_W'(in_inc);
    assign sum    = SUM_W'(drive_reg) + addend;

    // Clamp to the limits, upper test first
    always_comb
    begin
        if (sum > SUM_W'(upper))
        begin
            clamped = upper;
        end
        else if (sum < SUM_W'(lower))
        begin
            clamped = lower;
        end
        else
        begin
            clamped = sum[DRIVE_W-1:0];
        end
    end

    // Apply the action to drive and gate
    always_comb
    begin
        drive_next = drive_reg;
        gate_next  = gate_reg;
        held_next  = 1'b0;
        case (in_tag.action)
            ACT_COMPUTE:
            begin
                if (in_over && gate_reg)
                begin
                    held_next = 1'b1;
                end
                else
                begin
                    if (in_over)
                    begin
                        gate_next = 1'b1;
                    end
                    drive_next = clamped;
                end
            end
            ACT_SET_GATE:
            begin
                gate_next = in_tag.new_gate;
            end
            default: ;
        endcase
    end

    // Drive and gate double as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            drive_reg <= '0;
            gate_reg  <= 1'b0;
            held_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (load)
            begin
                drive_reg <= drive_next;
                gate_reg  <= gate_next;
                held_reg  <= held_next;
            end
        end
    end

    assign out_valid = valid_reg;
    assign drive     = drive_reg;
    assign gate      = gate_reg;
    assign held      = held_reg;

endmodule

[sv/incremental_pid_slow_start_unit.sv]
// Channel   Direction  Transaction content
// s_axis    in         tuser: action; tdata: measured, new_gate
// m_axis    out        tdata: drive, gate, held
// cfg       in         write enable, register index, write data
//
// A result passes four registered stages after its transaction is taken: error,
// products, increment, drive update. One transaction is taken every cycle while
// s_tready is high; the drive add and clamp loop through the drive register alone, which sets that rate.
// Reset clears the settings, the error history, the drive and the gate.
// A stalled result holds the full stages behind it while empty ones still fill;
// s_tready drops only once all four stages are full.
`include "incremental_pid_slow_start_unit_defines.svh"

module incremental_pid_slow_start_unit
    import ipss_pkg::*;
#(
    parameter int MEAS_WIDTH  = MEAS_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int IN_DATA_W  = ((MEAS_WIDTH + 1 + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((DRIVE_W + 2 + 7) / 8) * 8,
    localparam int ERR_W      = err_width(MEAS_WIDTH),
    localparam int INC_W      = COEF_W + ERR_W + 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // measured, new_gate, zero pad
    input  logic [1:0]            s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // drive, gate, held, zero pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                         cfg;
    tag_t                         in_tag;
    logic signed [MEAS_WIDTH-1:0] measured;

    logic                         a_valid;
    logic                         a_ready;
    tag_t                         a_tag;
    logic signed [ERR_W-1:0]      a_err;
    logic signed [ERR_W-1:0]      a_err_last;
    logic signed [ERR_W-1:0]      a_err_before;

    logic                         c_valid;
    logic                         c_ready;
    tag_t                         c_tag;
    logic signed [INC_W-1:0]      c_inc;
    logic                         c_over;

    logic signed [DRIVE_W-1:0]    out_drive;
    logic                         out_gate;
    logic                         out_held;
    logic                         d_load;

    // Unpack the input transaction
    assign measured        = s_tdata[MEAS_WIDTH-1:0];
    assign in_tag.action   = s_tuser;
    assign in_tag.new_gate = s_tdata[MEAS_WIDTH];

    ipss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipss_error #(
        .MEAS_WIDTH (MEAS_WIDTH)
    ) u_error (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_tag     (in_tag),
        .in_meas    (measured),
        .target     (cfg.target),
        .out_valid  (a_valid),
        .out_ready  (a_ready),
        .out_tag    (a_tag),
        .err        (a_err),
        .err_last   (a_err_last),
        .err_before (a_err_before)
    );

    ipss_increment #(
        .MEAS_WIDTH (MEAS_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_increment (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (a_valid),
        .in_ready   (a_ready),
        .in_tag     (a_tag),
        .err        (a_err),
        .err_last   (a_err_last),
        .err_before (a_err_before),
        .cfg        (cfg),
        .out_valid  (c_valid),
        .out_ready  (c_ready),
        .out_tag    (c_tag),
        .inc        (c_inc),
        .over       (c_over)
    );

    ipss_drive #(
        .MEAS_WIDTH (MEAS_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_drive (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_tag    (c_tag),
        .in_inc    (c_inc),
        .in_over   (c_over),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .drive     (out_drive),
        .gate      (out_gate),
        .held      (out_held),
        .load      (d_load)
    );

    // Pack the result transaction
    assign m_tdata = {(OUT_DATA_W - DRIVE_W - 2)'(0), out_held, out_gate, out_drive};

    // A held drive only ever comes with the slow-start gate
    `IPSS_ASSERT_IMPLY(a_held_gate, m_tvalid && out_held, out_gate,
                       "held result reported with gate normal")
    // Drive and gate move only when a result is loaded
    `IPSS_ASSERT_NEXT(a_drive_quiet, !d_load, $stable(out_drive),
                      "drive changed without a result load")
    `IPSS_ASSERT_NEXT(a_gate_quiet, !d_load, $stable(out_gate),
                      "gate changed without a result load")

endmodule
